FILE: sv/rmsm_pkg.sv
// rmsm_pkg: shared constants and state types of the block RMS level meter.
// No dependencies; every other file of the meter refers to it by scoped names.
`timescale 1ns / 1ps

package rmsm_pkg;

  localparam int MAX_BLOCK_DEF   = 4096;
  localparam int SAMPLE_BITS_DEF = 24;

  // accumulator and result widths
  localparam int SUM_W   = 59;
  localparam int ROOT_W  = (SUM_W + 1) / 2;
  localparam int RAD_W   = 2 * ROOT_W;
  localparam int LEVEL_W = 24;
  localparam int STEP_W  = $clog2(SUM_W);

  // job queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    FE_IDLE,
    FE_MUL,
    FE_ACC
  } front_state_t;

  typedef enum logic [1:0] {
    BE_IDLE,
    BE_DIV,
    BE_SQRT,
    BE_OUT
  } back_state_t;

endpackage

FILE: sv/rmsm_if.sv
// rmsm_if: valid/ready channel interfaces for samples in and RMS levels out.
// Depends on rmsm_pkg for the level width.
`timescale 1ns / 1ps

interface rmsm_in_if #(
  parameter int SAMPLE_BITS = rmsm_pkg::SAMPLE_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;
  logic                   last;

  modport source (output valid, output sample, output last, input ready);
  modport sink   (input valid, input sample, input last, output ready);
endinterface

interface rmsm_out_if;
  logic                         valid;
  logic                         ready;
  logic [rmsm_pkg::LEVEL_W-1:0] rms_level;
  logic                         overflow;

  modport source (output valid, output rms_level, output overflow, input ready);
  modport sink   (input valid, input rms_level, input overflow, output ready);
endinterface

FILE: sv/rmsm_front.sv
// rmsm_front: takes samples, squares them and keeps the block's sum and count.
// On the last sample of a block it hands a job to the queue. Uses rmsm_pkg, rmsm_if.
`timescale 1ns / 1ps

module rmsm_front #(
  parameter int SAMPLE_BITS = rmsm_pkg::SAMPLE_BITS_DEF,
  parameter int MAX_BLOCK   = rmsm_pkg::MAX_BLOCK_DEF,
  parameter int CNT_W       = $clog2(rmsm_pkg::MAX_BLOCK_DEF + 1)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  rmsm_in_if.sink                    in_ch,
  output logic                       job_valid,
  input  logic                       job_ready,
  output logic [rmsm_pkg::SUM_W-1:0] job_sum,
  output logic [CNT_W-1:0]           job_cnt,
  output logic                       job_sat
);

  localparam int SQ_BITS = 2 * SAMPLE_BITS;
  localparam int ACC_W   = ((SQ_BITS > rmsm_pkg::SUM_W) ? SQ_BITS : rmsm_pkg::SUM_W) + 1;

  rmsm_pkg::front_state_t state_r, state_nxt;

  logic [SAMPLE_BITS-1:0]     mag_r, mag_nxt;
  logic                       last_r, last_nxt;
  logic [SQ_BITS-1:0]         sq_r, sq_nxt;
  logic [rmsm_pkg::SUM_W-1:0] sum_r, sum_nxt;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic                       sat_r, sat_nxt;

  logic [ACC_W-1:0]           sum_ext;
  logic                       blk_full;
  logic [rmsm_pkg::SUM_W-1:0] acc_sum;
  logic [CNT_W-1:0]           acc_cnt;
  logic                       acc_sat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rmsm_pkg::FE_IDLE;
      sum_r   <= '0;
      cnt_r   <= '0;
      sat_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sum_r   <= sum_nxt;
      cnt_r   <= cnt_nxt;
      sat_r   <= sat_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r  <= mag_nxt;
    last_r <= last_nxt;
    sq_r   <= sq_nxt;
  end

  // one sample folded into the running state
  always_comb begin
    blk_full = (cnt_r >= CNT_W'(MAX_BLOCK));
    sum_ext  = ACC_W'(sum_r) + ACC_W'(sq_r);
    acc_sum  = sum_r;
    acc_cnt  = cnt_r;
    acc_sat  = sat_r;
    if (blk_full) begin
      acc_sat = 1'b1;
    end else begin
      acc_cnt = cnt_r + CNT_W'(1);
      if (sum_ext > ACC_W'({rmsm_pkg::SUM_W{1'b1}})) begin
        acc_sum = {rmsm_pkg::SUM_W{1'b1}};
        acc_sat = 1'b1;
      end else begin
        acc_sum = sum_ext[rmsm_pkg::SUM_W-1:0];
      end
    end
  end

  always_comb begin
    state_nxt   = state_r;
    mag_nxt     = mag_r;
    last_nxt    = last_r;
    sq_nxt      = sq_r;
    sum_nxt     = sum_r;
    cnt_nxt     = cnt_r;
    sat_nxt     = sat_r;
    in_ch.ready = 1'b0;
    job_valid   = 1'b0;
    job_sum     = acc_sum;
    job_cnt     = acc_cnt;
    job_sat     = acc_sat;
    case (state_r)
      rmsm_pkg::FE_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          mag_nxt   = in_ch.sample[SAMPLE_BITS-1] ?
                      SAMPLE_BITS'(~in_ch.sample + SAMPLE_BITS'(1)) : in_ch.sample;
          last_nxt  = in_ch.last;
          state_nxt = rmsm_pkg::FE_MUL;
        end
      end
      rmsm_pkg::FE_MUL: begin
        sq_nxt    = SQ_BITS'(mag_r) * SQ_BITS'(mag_r);
        state_nxt = rmsm_pkg::FE_ACC;
      end
      rmsm_pkg::FE_ACC: begin
        job_valid = last_r;
        if (!last_r) begin
          sum_nxt   = acc_sum;
          cnt_nxt   = acc_cnt;
          sat_nxt   = acc_sat;
          state_nxt = rmsm_pkg::FE_IDLE;
        end else if (job_ready) begin
          sum_nxt   = '0;
          cnt_nxt   = '0;
          sat_nxt   = 1'b0;
          state_nxt = rmsm_pkg::FE_IDLE;
        end
      end
      default: begin
        state_nxt = rmsm_pkg::FE_IDLE;
      end
    endcase
  end

endmodule

FILE: sv/rmsm_queue.sv
// rmsm_queue: short first-in first-out queue of finished block jobs.
// Sits between front and back; depth from rmsm_pkg.
`timescale 1ns / 1ps

module rmsm_queue #(
  parameter int DATA_W = rmsm_pkg::SUM_W + 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_valid,
  output logic              wr_ready,
  input  logic [DATA_W-1:0] wr_data,
  output logic              rd_valid,
  input  logic              rd_ready,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0]           mem_r [rmsm_pkg::QUEUE_DEPTH];
  logic [rmsm_pkg::QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [rmsm_pkg::QCNT_W-1:0] fill_r;
  logic                        push, pop;

  assign wr_ready = (fill_r != rmsm_pkg::QCNT_W'(rmsm_pkg::QUEUE_DEPTH));
  assign rd_valid = (fill_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + rmsm_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + rmsm_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
        fill_r <= fill_r + rmsm_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
        fill_r <= fill_r - rmsm_pkg::QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

FILE: sv/rmsm_back.sv
// rmsm_back: divides a block's sum by its count one bit a cycle (skipped for a
// zero count, which gives level zero), then takes the floor square root two bits a
// cycle, and holds the level in the output register. Uses rmsm_pkg and rmsm_if.
`timescale 1ns / 1ps

module rmsm_back #(
  parameter int CNT_W = $clog2(rmsm_pkg::MAX_BLOCK_DEF + 1)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       job_valid,
  output logic                       job_ready,
  input  logic [rmsm_pkg::SUM_W-1:0] job_sum,
  input  logic [CNT_W-1:0]           job_cnt,
  input  logic                       job_sat,
  rmsm_out_if.source                 out_ch
);

  localparam int SUM_W  = rmsm_pkg::SUM_W;
  localparam int ROOT_W = rmsm_pkg::ROOT_W;
  localparam int RAD_W  = rmsm_pkg::RAD_W;
  localparam int STEP_W = rmsm_pkg::STEP_W;
  localparam int LVL_W  = rmsm_pkg::LEVEL_W;

  rmsm_pkg::back_state_t state_r, state_nxt;

  logic [STEP_W-1:0] step_r, step_nxt;
  logic [SUM_W-1:0]  q_r, q_nxt;
  logic [CNT_W-1:0]  div_r, div_nxt;
  logic [CNT_W-1:0]  drem_r, drem_nxt;
  logic [RAD_W-1:0]  x_r, x_nxt;
  logic [ROOT_W+1:0] srem_r, srem_nxt;
  logic [ROOT_W-1:0] root_r, root_nxt;
  logic              sat_r, sat_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [LVL_W-1:0]  out_level_r, out_level_nxt;
  logic              out_ovf_r, out_ovf_nxt;

  logic [CNT_W:0]    d_trial;
  logic              d_ge;
  logic [ROOT_W+3:0] s_trial, s_test;
  logic              s_ge;
  logic              out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rmsm_pkg::BE_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r      <= step_nxt;
    q_r         <= q_nxt;
    div_r       <= div_nxt;
    drem_r      <= drem_nxt;
    x_r         <= x_nxt;
    srem_r      <= srem_nxt;
    root_r      <= root_nxt;
    sat_r       <= sat_nxt;
    out_level_r <= out_level_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.rms_level = out_level_r;
  assign out_ch.overflow  = out_ovf_r;
  assign out_free         = !out_valid_r || out_ch.ready;

  // restoring division step and square-root digit step
  always_comb begin
    d_trial = {drem_r, q_r[SUM_W-1]};
    d_ge    = (d_trial >= {1'b0, div_r});
    s_trial = {srem_r, x_r[RAD_W-1 -: 2]};
    s_test  = (ROOT_W+4)'({root_r, 2'b01});
    s_ge    = (s_trial >= s_test);
  end

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    q_nxt         = q_r;
    div_nxt       = div_r;
    drem_nxt      = drem_r;
    x_nxt         = x_r;
    srem_nxt      = srem_r;
    root_nxt      = root_r;
    sat_nxt       = sat_r;
    out_level_nxt = out_level_r;
    out_ovf_nxt   = out_ovf_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    job_ready     = 1'b0;
    case (state_r)
      rmsm_pkg::BE_IDLE: begin
        job_ready = 1'b1;
        if (job_valid) begin
          q_nxt    = job_sum;
          div_nxt  = job_cnt;
          drem_nxt = '0;
          sat_nxt  = job_sat;
          step_nxt = '0;
          x_nxt    = '0;
          srem_nxt = '0;
          root_nxt = '0;
          if (job_cnt == '0) begin
            state_nxt = rmsm_pkg::BE_SQRT;
          end else begin
            state_nxt = rmsm_pkg::BE_DIV;
          end
        end
      end
      rmsm_pkg::BE_DIV: begin
        q_nxt    = {q_r[SUM_W-2:0], d_ge};
        drem_nxt = d_ge ? CNT_W'(d_trial - {1'b0, div_r}) : CNT_W'(d_trial);
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(SUM_W - 1)) begin
          x_nxt     = RAD_W'(q_nxt);
          srem_nxt  = '0;
          root_nxt  = '0;
          step_nxt  = '0;
          state_nxt = rmsm_pkg::BE_SQRT;
        end
      end
      rmsm_pkg::BE_SQRT: begin
        srem_nxt = s_ge ? (ROOT_W+2)'(s_trial - s_test) : (ROOT_W+2)'(s_trial);
        root_nxt = {root_r[ROOT_W-2:0], s_ge};
        x_nxt    = x_r << 2;
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(ROOT_W - 1)) begin
          state_nxt = rmsm_pkg::BE_OUT;
        end
      end
      rmsm_pkg::BE_OUT: begin
        if (out_free) begin
          out_level_nxt = (root_r > ROOT_W'({LVL_W{1'b1}})) ?
                          {LVL_W{1'b1}} : root_r[LVL_W-1:0];
          out_ovf_nxt   = sat_r;
          out_valid_nxt = 1'b1;
          state_nxt     = rmsm_pkg::BE_IDLE;
        end
      end
      default: begin
        state_nxt = rmsm_pkg::BE_IDLE;
      end
    endcase
  end

endmodule

FILE: sv/block_rms_level_meter.sv
// block_rms_level_meter: block RMS level meter, top level (front, job queue, back).
// The front takes, squares and accumulates each sample before it takes the next one.
// After a block's last sample the front hands a job to the queue; the back then runs 59
// divide steps, 30 root steps and loads 1 output register; two jobs may queue.
// Reset (rst_n low, synchronous) clears sum, count, overflow flag, queue and output valid.
// Depends on rmsm_pkg, rmsm_if, rmsm_front, rmsm_queue and rmsm_back.
`timescale 1ns / 1ps

module block_rms_level_meter #(
  parameter int MAX_BLOCK   = rmsm_pkg::MAX_BLOCK_DEF,
  parameter int SAMPLE_BITS = rmsm_pkg::SAMPLE_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  rmsm_in_if.sink    in_ch,
  rmsm_out_if.source out_ch
);

  localparam int CNT_W = $clog2(MAX_BLOCK + 1);
  localparam int JOB_W = rmsm_pkg::SUM_W + CNT_W + 1;

  logic                       f_valid, f_ready;
  logic [rmsm_pkg::SUM_W-1:0] f_sum;
  logic [CNT_W-1:0]           f_cnt;
  logic                       f_sat;
  logic                       b_valid, b_ready;
  logic [JOB_W-1:0]           b_data;

  rmsm_front #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .MAX_BLOCK   (MAX_BLOCK),
    .CNT_W       (CNT_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .job_valid (f_valid),
    .job_ready (f_ready),
    .job_sum   (f_sum),
    .job_cnt   (f_cnt),
    .job_sat   (f_sat)
  );

  rmsm_queue #(
    .DATA_W (JOB_W)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_data  ({f_sat, f_cnt, f_sum}),
    .rd_valid (b_valid),
    .rd_ready (b_ready),
    .rd_data  (b_data)
  );

  rmsm_back #(
    .CNT_W (CNT_W)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (b_valid),
    .job_ready (b_ready),
    .job_sum   (b_data[rmsm_pkg::SUM_W-1:0]),
    .job_cnt   (b_data[rmsm_pkg::SUM_W +: CNT_W]),
    .job_sat   (b_data[JOB_W-1]),
    .out_ch    (out_ch)
  );

endmodule
